/* rtl/jas_pkg.sv */
package jas_pkg;

    // Quotient bits produced by the divider: norm in Q0.16 plus the unit bit.
    localparam int unsigned QUO_BITS = 17;
    // Width of one curve table entry (exp2 entries reach 2.0 in Q16).
    localparam int unsigned TAB_W    = 18;
    // Full travel in percent, Q8.
    localparam int unsigned LIN_FULL = 25600;
    localparam int unsigned EXPO_CAP = 768;
    localparam int unsigned LIM_CAP  = 100;

    typedef struct packed {
        logic cmd;
        logic neg;
        logic dbf;
    } t_side;

endpackage

/* rtl/joystick_axis_shaper.sv */
// Joystick axis shaper: one converter sample in, one signed percent out.
//
// Input: pulse start with i_cmd and i_raw_sample; a beat is taken on every
// edge with start high and busy low. busy is never raised, so a new sample
// may be issued on every clock.
// Output: o_strobe is high for one cycle with o_position (Q8 percent,
// -25600..25600) and o_in_dead_band. The receiver cannot hold results off
// and none is needed: the pipeline never stalls.
// Pipeline: 34 register stages (3 front, 1+17 divider steps, 13 curve).
// Throughput is one sample per cycle, set by the fully pipelined restoring
// divider.
// Configuration: i_cfg_we writes register i_cfg_idx from i_cfg_data at once;
// unused indexes are ignored. Write only while no sample is in flight.
// Deadband, expo and limit are held at their caps when written.
// Reset (synchronous, active low) empties the pipeline and restores the
// register defaults; nothing else needs clearing.
module joystick_axis_shaper import jas_pkg::*; #(
    parameter int unsigned SAMPLE_BITS       = 12,
    parameter int unsigned CURVE_TABLE_DEPTH = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_raw_sample,
    output logic                   o_strobe,
    output logic signed [15:0]     o_position,
    output logic                   o_in_dead_band,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [((SAMPLE_BITS > 11) ? SAMPLE_BITS : 11)-1:0] i_cfg_data
);

    localparam int unsigned SB     = SAMPLE_BITS;
    localparam int unsigned NW     = SB + QUO_BITS;
    localparam int unsigned DZ_CAP = ((2**SB - 1) * 400) / 1023;

    typedef enum logic [2:0] {
        CFG_INVERT    = 3'd0,
        CFG_CAL_LOW   = 3'd1,
        CFG_CAL_HIGH  = 3'd2,
        CFG_CAL_MID   = 3'd3,
        CFG_DEAD_BAND = 3'd4,
        CFG_EXPO      = 3'd5,
        CFG_LIMIT     = 3'd6
    } t_cfg_idx;

    logic          r_invert;
    logic [SB-1:0] r_cal_low, r_cal_high, r_cal_mid;
    logic [10:0]   r_dz;
    logic [9:0]    r_expo;
    logic [6:0]    r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert   <= 1'b0;
            r_cal_low  <= '0;
            r_cal_high <= '1;
            r_cal_mid  <= {1'b0, {(SB-1){1'b1}}};
            r_dz       <= '0;
            r_expo     <= '0;
            r_limit    <= 7'(LIM_CAP);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_INVERT:    r_invert   <= i_cfg_data[0];
                CFG_CAL_LOW:   r_cal_low  <= i_cfg_data[SB-1:0];
                CFG_CAL_HIGH:  r_cal_high <= i_cfg_data[SB-1:0];
                CFG_CAL_MID:   r_cal_mid  <= i_cfg_data[SB-1:0];
                CFG_DEAD_BAND: r_dz <= (32'(i_cfg_data[10:0]) > DZ_CAP) ?
                                       11'(DZ_CAP) : i_cfg_data[10:0];
                CFG_EXPO:      r_expo <= (32'(i_cfg_data[9:0]) > EXPO_CAP) ?
                                         10'(EXPO_CAP) : i_cfg_data[9:0];
                CFG_LIMIT:     r_limit <= (32'(i_cfg_data[6:0]) > LIM_CAP) ?
                                          7'(LIM_CAP) : i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic              f_vld;
    t_side             f_side;
    logic [NW-1:0]     f_num;
    logic [SB-1:0]     f_den;
    logic              d_vld, d_big;
    t_side             d_side;
    logic [QUO_BITS-1:0] d_quo;

    jas_front #(.SB(SB)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (start && !busy),
        .i_cmd      (i_cmd),
        .i_raw      (i_raw_sample),
        .i_invert   (r_invert),
        .i_cal_low  (r_cal_low),
        .i_cal_high (r_cal_high),
        .i_cal_mid  (r_cal_mid),
        .i_dz       (r_dz),
        .o_vld      (f_vld),
        .o_side     (f_side),
        .o_num      (f_num),
        .o_den      (f_den)
    );

    jas_div #(.DW(SB), .QB(QUO_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_side  (f_side),
        .i_num   (f_num),
        .i_den   (f_den),
        .o_vld   (d_vld),
        .o_side  (d_side),
        .o_quo   (d_quo),
        .o_big   (d_big)
    );

    jas_curve #(.DEPTH(CURVE_TABLE_DEPTH)) u_curve (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (d_vld),
        .i_side     (d_side),
        .i_quo      (d_quo),
        .i_big      (d_big),
        .i_expo     (r_expo),
        .i_limit    (r_limit),
        .o_vld      (o_strobe),
        .o_position (o_position),
        .o_dbf      (o_in_dead_band)
    );

`ifndef ASSERT_OFF
    a_dead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_in_dead_band) |-> o_position == 16'sd0)
        else $error("deadzone beat with nonzero position");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_position <= 16'sd25600 && o_position >= -16'sd25600))
        else $error("position out of range");
`endif

endmodule

/* rtl/jas_front.sv */
module jas_front import jas_pkg::*; #(
    parameter int unsigned SB = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic                     i_cmd,
    input  logic [SB-1:0]            i_raw,
    input  logic                     i_invert,
    input  logic [SB-1:0]            i_cal_low,
    input  logic [SB-1:0]            i_cal_high,
    input  logic [SB-1:0]            i_cal_mid,
    input  logic [10:0]              i_dz,
    output logic                     o_vld,
    output t_side                    o_side,
    output logic [SB+QUO_BITS-1:0]   o_num,
    output logic [SB-1:0]            o_den
);

    localparam int unsigned NW = SB + QUO_BITS;
    localparam logic [SB-1:0] FULL = '1;

    // stage A: mirror, calibration fallback
    logic          r_a_vld, r_a_cmd;
    logic [SB-1:0] r_a_raw, r_a_lo, r_a_hi, r_a_ctr;
    logic [SB-1:0] n_a_raw, n_a_lo, n_a_hi, n_a_ctr;
    logic          degen;
    logic [SB:0]   mid_sum;

    always_comb begin
        n_a_raw = i_invert ? FULL - i_raw : i_raw;
        degen   = ({1'b0, i_cal_high} <= ({1'b0, i_cal_low} + (SB+1)'(2)));
        n_a_lo  = degen ? '0 : i_cal_low;
        n_a_hi  = degen ? FULL : i_cal_high;
        mid_sum = {1'b0, n_a_lo} + {1'b0, n_a_hi};
        n_a_ctr = (i_cal_mid < n_a_lo || i_cal_mid > n_a_hi) ? mid_sum[SB:1] : i_cal_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
        end
        r_a_cmd <= i_cmd;
        r_a_raw <= n_a_raw;
        r_a_lo  <= n_a_lo;
        r_a_hi  <= n_a_hi;
        r_a_ctr <= n_a_ctr;
    end

    // stage B: distance from center and span of that side
    logic          r_b_vld, r_b_cmd, r_b_neg;
    logic [SB-1:0] r_b_absd, r_b_span;
    logic [SB-1:0] sp_pos, sp_neg;
    logic          n_b_neg;

    always_comb begin
        sp_pos  = r_a_hi - r_a_ctr;
        sp_neg  = r_a_ctr - r_a_lo;
        if (sp_pos == '0) sp_pos = SB'(1);
        if (sp_neg == '0) sp_neg = SB'(1);
        n_b_neg = r_a_raw < r_a_ctr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_cmd  <= r_a_cmd;
        r_b_neg  <= n_b_neg;
        r_b_absd <= n_b_neg ? r_a_ctr - r_a_raw : r_a_raw - r_a_ctr;
        r_b_span <= n_b_neg ? sp_neg : sp_pos;
    end

    // stage C: deadzone and divider operands
    logic [SB-1:0] dzs;
    logic          hit;
    t_side         n_side;
    logic [NW-1:0] n_num;
    logic [SB-1:0] n_den;

    always_comb begin
        dzs        = SB'(i_dz);
        hit        = !r_b_cmd && (r_b_absd <= dzs || r_b_span <= dzs);
        n_side.cmd = r_b_cmd;
        n_side.neg = r_b_neg;
        n_side.dbf = hit;
        if (r_b_cmd) begin
            n_num = NW'(r_b_absd) * NW'(LIN_FULL) + NW'(r_b_span >> 1);
            n_den = r_b_span;
        end else if (hit) begin
            n_num = '0;
            n_den = SB'(1);
        end else begin
            n_num = NW'(r_b_absd - dzs) << 16;
            n_den = r_b_span - dzs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= r_b_vld;
        end
        o_side <= n_side;
        o_num  <= n_num;
        o_den  <= n_den;
    end

endmodule

/* rtl/jas_div.sv */
module jas_div import jas_pkg::*; #(
    parameter int unsigned DW = 12,
    parameter int unsigned QB = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  t_side            i_side,
    input  logic [DW+QB-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    output logic             o_vld,
    output t_side            o_side,
    output logic [QB-1:0]    o_quo,
    output logic             o_big
);

    logic          r_vld  [0:QB];
    t_side         r_side [0:QB];
    logic [DW-1:0] r_rem  [0:QB];
    logic [DW-1:0] r_den  [0:QB];
    logic [QB-1:0] r_low  [0:QB];
    logic [QB-1:0] r_quo  [0:QB];
    logic          r_big  [0:QB];
    logic          big;

    // quotient does not fit when the upper numerator bits reach the divisor
    assign big = i_num[DW+QB-1:QB] >= i_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_side[0] <= i_side;
        r_rem[0]  <= big ? '0 : i_num[DW+QB-1:QB];
        r_den[0]  <= i_den;
        r_low[0]  <= i_num[QB-1:0];
        r_quo[0]  <= '0;
        r_big[0]  <= big;
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [DW:0] trial;
        logic        take;
        assign trial = {r_rem[k], r_low[k][QB-1]};
        assign take  = trial >= {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_side[k+1] <= r_side[k];
            r_rem[k+1]  <= take ? DW'(trial - {1'b0, r_den[k]}) : DW'(trial);
            r_den[k+1]  <= r_den[k];
            r_low[k+1]  <= r_low[k] << 1;
            r_quo[k+1]  <= {r_quo[k][QB-2:0], take};
            r_big[k+1]  <= r_big[k];
        end
    end

    assign o_vld  = r_vld[QB];
    assign o_side = r_side[QB];
    assign o_quo  = r_quo[QB];
    assign o_big  = r_big[QB];

`ifndef ASSERT_OFF
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QB] |-> r_rem[QB] < r_den[QB])
        else $error("divider remainder not below divisor");
`endif

endmodule

/* rtl/jas_curve.sv */
module jas_curve import jas_pkg::*; #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  t_side               i_side,
    input  logic [QUO_BITS-1:0] i_quo,
    input  logic                i_big,
    input  logic [9:0]          i_expo,
    input  logic [6:0]          i_limit,
    output logic                o_vld,
    output logic signed [15:0]  o_position,
    output logic                o_dbf
);

    localparam int unsigned IW = $clog2(DEPTH + 1);
    localparam int unsigned PW = 16 + IW;

    function automatic logic [17:0] bit_log2(input logic [17:0] x);
        logic [35:0] z;
        logic [17:0] y;
        z = 36'(x);
        y = '0;
        for (int b = 15; b >= 0; b--) begin
            z = (z * z) >> 16;
            if (z >= 36'd131072) begin
                z = z >> 1;
                y[b] = 1'b1;
            end
        end
        return y;
    endfunction

    function automatic logic [(DEPTH+1)*TAB_W-1:0] build_log();
        logic [(DEPTH+1)*TAB_W-1:0] v;
        logic [17:0]                t;
        v = '0;
        for (int i = 0; i < DEPTH; i++) begin
            t = 18'((i * 65536) / DEPTH);
            v[i*TAB_W +: TAB_W] = TAB_W'(bit_log2(18'd65536 + t));
        end
        v[DEPTH*TAB_W +: TAB_W] = TAB_W'(65536);
        return v;
    endfunction

    function automatic logic [(DEPTH+1)*TAB_W-1:0] build_exp();
        logic [(DEPTH+1)*TAB_W-1:0] v;
        int unsigned                t, lo, hi, mid;
        v = '0;
        for (int i = 0; i < DEPTH; i++) begin
            t  = (i * 65536) / DEPTH;
            lo = 65536;
            hi = 131072;
            for (int k = 0; k < 18; k++) begin
                if (lo < hi) begin
                    mid = lo + ((hi - lo) >> 1);
                    if (32'(bit_log2(18'(mid))) >= t) hi = mid;
                    else lo = mid + 1;
                end
            end
            v[i*TAB_W +: TAB_W] = TAB_W'(lo);
        end
        v[DEPTH*TAB_W +: TAB_W] = TAB_W'(131072);
        return v;
    endfunction

    localparam logic [(DEPTH+1)*TAB_W-1:0] LOG_TAB = build_log();
    localparam logic [(DEPTH+1)*TAB_W-1:0] EXP_TAB = build_exp();

    // C1: saturate quotient
    logic        r1_vld;
    t_side       r1_side;
    logic [16:0] r1_n;
    logic [14:0] r1_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        r1_side <= i_side;
        r1_n    <= (i_big || i_quo > 17'h10000) ? 17'h10000 : i_quo;
        r1_lin  <= (i_big || i_quo > 17'(LIN_FULL)) ? 15'(LIN_FULL) : i_quo[14:0];
    end

    // C2: normalizing shift
    logic        r2_vld, r2_one, r2_zero;
    t_side       r2_side;
    logic [15:0] r2_n;
    logic [4:0]  r2_s;
    logic [14:0] r2_lin;
    logic [4:0]  msb;

    always_comb begin
        msb = '0;
        for (int i = 0; i < 16; i++) begin
            if (r1_n[i]) msb = 5'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_side <= r1_side;
        r2_n    <= r1_n[15:0];
        r2_s    <= 5'd16 - msb;
        r2_one  <= r1_n[16];
        r2_zero <= (r1_n == '0);
        r2_lin  <= r1_lin;
    end

    // C3: log2 table index and weight
    logic          r3_vld, r3_one, r3_zero;
    t_side         r3_side;
    logic [4:0]    r3_s;
    logic [IW-1:0] r3_idx;
    logic [15:0]   r3_w;
    logic [14:0]   r3_lin;
    logic [31:0]   m_sh;
    logic [PW-1:0] p_log;

    always_comb begin
        m_sh  = {16'b0, r2_n} << r2_s;
        p_log = PW'(m_sh[15:0]) * PW'(DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_side <= r2_side;
        r3_one  <= r2_one;
        r3_zero <= r2_zero;
        r3_s    <= r2_s;
        r3_idx  <= p_log[PW-1:16];
        r3_w    <= p_log[15:0];
        r3_lin  <= r2_lin;
    end

    // C4: log2 table read
    logic             r4_vld, r4_one, r4_zero;
    t_side            r4_side;
    logic [4:0]       r4_s;
    logic [TAB_W-1:0] r4_a, r4_b;
    logic [15:0]      r4_w;
    logic [14:0]      r4_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_side <= r3_side;
        r4_one  <= r3_one;
        r4_zero <= r3_zero;
        r4_s    <= r3_s;
        r4_a    <= LOG_TAB[r3_idx*TAB_W +: TAB_W];
        r4_b    <= LOG_TAB[IW'(r3_idx + 1'b1)*TAB_W +: TAB_W];
        r4_w    <= r3_w;
        r4_lin  <= r3_lin;
    end

    // C5: interpolation product
    logic             r5_vld, r5_one, r5_zero;
    t_side            r5_side;
    logic [4:0]       r5_s;
    logic [TAB_W-1:0] r5_a, r5_d;
    logic [14:0]      r5_lin;
    logic [33:0]      dp_log;

    assign dp_log = 34'(r4_b - r4_a) * 34'(r4_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_side <= r4_side;
        r5_one  <= r4_one;
        r5_zero <= r4_zero;
        r5_s    <= r4_s;
        r5_a    <= r4_a;
        r5_d    <= (r4_b > r4_a) ? dp_log[33:16] : '0;
        r5_lin  <= r4_lin;
    end

    // C6: magnitude of log2(norm)
    logic        r6_vld, r6_one, r6_zero;
    t_side       r6_side;
    logic [20:0] r6_neg;
    logic [14:0] r6_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
        r6_side <= r5_side;
        r6_one  <= r5_one;
        r6_zero <= r5_zero;
        r6_neg  <= (21'(r5_s) << 16) - 21'(r5_a + r5_d);
        r6_lin  <= r5_lin;
    end

    // C7: scale by exponent
    logic        r7_vld, r7_one, r7_zero;
    t_side       r7_side;
    logic [31:0] r7_mag;
    logic [14:0] r7_lin;
    logic [10:0] pexp;

    assign pexp = 11'd256 + 11'(i_expo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
        r7_side <= r6_side;
        r7_one  <= r6_one;
        r7_zero <= r6_zero;
        r7_mag  <= 32'(r6_neg) * 32'(pexp);
        r7_lin  <= r6_lin;
    end

    // C8: exp2 table index and weight
    logic          r8_vld, r8_one, r8_zero, r8_rz;
    t_side         r8_side;
    logic [7:0]    r8_q;
    logic [IW-1:0] r8_idx;
    logic [15:0]   r8_w;
    logic [14:0]   r8_lin;
    logic [15:0]   frac;
    logic [PW-1:0] p_exp;

    always_comb begin
        frac  = 16'(17'h10000 - 17'(r7_mag[23:8]));
        p_exp = PW'(frac) * PW'(DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else begin
            r8_vld <= r7_vld;
        end
        r8_side <= r7_side;
        r8_one  <= r7_one;
        r8_zero <= r7_zero;
        r8_rz   <= (r7_mag[23:8] == '0);
        r8_q    <= r7_mag[31:24];
        r8_idx  <= p_exp[PW-1:16];
        r8_w    <= p_exp[15:0];
        r8_lin  <= r7_lin;
    end

    // C9: exp2 table read
    logic             r9_vld, r9_one, r9_zero, r9_rz;
    t_side            r9_side;
    logic [7:0]       r9_q;
    logic [TAB_W-1:0] r9_a, r9_b;
    logic [15:0]      r9_w;
    logic [14:0]      r9_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else begin
            r9_vld <= r8_vld;
        end
        r9_side <= r8_side;
        r9_one  <= r8_one;
        r9_zero <= r8_zero;
        r9_rz   <= r8_rz;
        r9_q    <= r8_q;
        r9_a    <= EXP_TAB[r8_idx*TAB_W +: TAB_W];
        r9_b    <= EXP_TAB[IW'(r8_idx + 1'b1)*TAB_W +: TAB_W];
        r9_w    <= r8_w;
        r9_lin  <= r8_lin;
    end

    // C10: interpolation product
    logic             r10_vld, r10_one, r10_zero, r10_rz;
    t_side            r10_side;
    logic [7:0]       r10_q;
    logic [TAB_W-1:0] r10_a, r10_d;
    logic [14:0]      r10_lin;
    logic [33:0]      dp_exp;

    assign dp_exp = 34'(r9_b - r9_a) * 34'(r9_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else begin
            r10_vld <= r9_vld;
        end
        r10_side <= r9_side;
        r10_one  <= r9_one;
        r10_zero <= r9_zero;
        r10_rz   <= r9_rz;
        r10_q    <= r9_q;
        r10_a    <= r9_a;
        r10_d    <= (r9_b > r9_a) ? dp_exp[33:16] : '0;
        r10_lin  <= r9_lin;
    end

    // C11: curve value
    logic             r11_vld;
    t_side            r11_side;
    logic [16:0]      r11_c;
    logic [14:0]      r11_lin;
    logic [TAB_W-1:0] e_val;
    logic [16:0]      n_c;

    always_comb begin
        e_val = r10_a + r10_d;
        priority if (r10_one) begin
            n_c = 17'h10000;
        end else if (r10_zero) begin
            n_c = '0;
        end else if (r10_q >= 8'd17) begin
            n_c = '0;
        end else if (r10_rz) begin
            n_c = 17'h10000 >> r10_q;
        end else begin
            n_c = 17'(e_val >> (9'(r10_q) + 9'd1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_vld <= 1'b0;
        end else begin
            r11_vld <= r10_vld;
        end
        r11_side <= r10_side;
        r11_c    <= n_c;
        r11_lin  <= r10_lin;
    end

    // C12: limit scaling, linear result or deadband zero
    logic        r12_vld;
    t_side       r12_side;
    logic [14:0] r12_mag;
    logic [24:0] lim_prod;

    assign lim_prod = 25'(r11_c) * 25'(i_limit) + 25'd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_vld <= 1'b0;
        end else begin
            r12_vld <= r11_vld;
        end
        r12_side <= r11_side;
        priority if (r11_side.cmd) begin
            r12_mag <= r11_lin;
        end else if (r11_side.dbf) begin
            r12_mag <= '0;
        end else begin
            r12_mag <= 15'(lim_prod >> 8);
        end
    end

    // C13: apply sign, drive result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= r12_vld;
        end
        o_position <= r12_side.neg ? -$signed({1'b0, r12_mag}) : $signed({1'b0, r12_mag});
        o_dbf      <= r12_side.dbf && !r12_side.cmd;
    end

`ifndef ASSERT_OFF
    a_curve_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r11_vld |-> r11_c <= 17'h10000)
        else $error("curve value above unity");
    a_dbf_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r12_vld && r12_side.dbf) |-> (r12_mag == '0 && !r12_side.cmd))
        else $error("deadzone beat with nonzero magnitude");
`endif

endmodule

/* sim/tb.sv */
module tb import jas_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FULL    = 4095;
    localparam int unsigned DZ_MAX  = (FULL * 400) / 1023;
    localparam int unsigned DEPTH   = 256;
    localparam int unsigned UNIT    = 65536;
    localparam int          DRAIN   = 40;

    typedef enum logic [2:0] {
        REG_INVERT = 3'd0,
        REG_LOW    = 3'd1,
        REG_HIGH   = 3'd2,
        REG_MID    = 3'd3,
        REG_DEAD   = 3'd4,
        REG_EXPO   = 3'd5,
        REG_LIMIT  = 3'd6,
        REG_NONE   = 3'd7
    } t_reg_idx;

    typedef enum logic {
        CMD_SHAPED = 1'b0,
        CMD_LINEAR = 1'b1
    } t_cmd;

    typedef struct {
        logic        cmd;
        logic [11:0] raw;
    } t_sample;

    typedef struct {
        logic [15:0] pos;
        logic        dbf;
    } t_stick;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cmd = 1'b0;
    logic [11:0] i_raw_sample = '0;
    logic        o_strobe;
    logic signed [15:0] o_position;
    logic        o_in_dead_band;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [11:0] i_cfg_data = '0;

    joystick_axis_shaper DUT (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow copy of the register file
    int unsigned sh_invert = 0, sh_low = 0, sh_high = 4095, sh_mid = 2047;
    int unsigned sh_dead = 0, sh_expo = 0, sh_limit = 100;

    int unsigned log_t [0:DEPTH];
    int unsigned exp_t [0:DEPTH];

    t_sample pending_q[$];
    t_stick  want_q[$];
    int      errors = 0;
    int      results_seen = 0;
    int      shaped_seen = 0;
    int      dead_seen = 0;
    bit      quiet_phase = 1'b0;

    function automatic int unsigned fx_log2(int unsigned x);
        longint unsigned z;
        int unsigned y;
        z = x;
        y = 0;
        for (int b = 15; b >= 0; b--) begin
            z = (z * z) >> 16;
            if (z >= 2 * UNIT) begin
                z = z >> 1;
                y |= 32'd1 << b;
            end
        end
        return y;
    endfunction

    function automatic void build_curves();
        int unsigned t, lo, hi, mid;
        for (int i = 0; i < DEPTH; i++) begin
            t = int'((longint'(i) << 16) / DEPTH);
            log_t[i] = fx_log2(UNIT + t);
            lo = UNIT;
            hi = 2 * UNIT;
            while (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (fx_log2(mid) >= t) hi = mid;
                else lo = mid + 1;
            end
            exp_t[i] = lo;
        end
        log_t[DEPTH] = UNIT;
        exp_t[DEPTH] = 2 * UNIT;
    endfunction

    function automatic int unsigned interp_curve(bit use_exp, int unsigned f);
        longint unsigned prod;
        int unsigned idx, w, a, b;
        prod = longint'(f & 16'hFFFF) * DEPTH;
        idx = int'(prod >> 16);
        w = int'(prod & 16'hFFFF);
        if (idx >= DEPTH) idx = DEPTH - 1;
        a = use_exp ? exp_t[idx] : log_t[idx];
        b = use_exp ? exp_t[idx + 1] : log_t[idx + 1];
        return a + ((b > a) ? int'((longint'(b - a) * w) >> 16) : 0);
    endfunction

    function automatic int unsigned curve_power(int unsigned n, int unsigned p);
        int unsigned m, s, lg, q, r, e, sh;
        longint unsigned nl, ml;
        if (n >= UNIT) return UNIT;
        if (n == 0) return 0;
        m = n;
        s = 0;
        while (m < UNIT) begin
            m = m << 1;
            s++;
        end
        lg = interp_curve(1'b0, m - UNIT);
        nl = longint'(s) * UNIT - lg;
        ml = (nl * p) >> 8;
        q = int'(ml >> 16);
        r = int'(ml & 16'hFFFF);
        if (r == 0) return (q >= 17) ? 0 : (UNIT >> q);
        e = interp_curve(1'b1, UNIT - r);
        sh = q + 1;
        return (sh >= 18) ? 0 : (e >> sh);
    endfunction

    function automatic t_stick shape_sample(logic cmd, logic [11:0] raw_in);
        int raw, lo, hi, ctr, sp_pos, sp_neg, d, absd, span, dz;
        int unsigned mag, ex, lim, c;
        longint unsigned nq, v;
        bit neg;
        t_stick res;
        raw = raw_in;
        lo = sh_low;
        hi = sh_high;
        ctr = sh_mid;
        res.dbf = 1'b0;
        mag = 0;
        if (raw > FULL) raw = FULL;
        if (sh_invert != 0) raw = FULL - raw;
        if (hi <= lo + 2) begin
            lo = 0;
            hi = FULL;
        end
        if (ctr < lo || ctr > hi) ctr = (lo + hi) / 2;
        sp_pos = (hi - ctr < 1) ? 1 : hi - ctr;
        sp_neg = (ctr - lo < 1) ? 1 : ctr - lo;
        d = raw - ctr;
        neg = d < 0;
        absd = neg ? -d : d;
        span = neg ? sp_neg : sp_pos;
        if (cmd == CMD_SHAPED) begin
            dz = (sh_dead > DZ_MAX) ? DZ_MAX : sh_dead;
            if (absd <= dz || span <= dz) begin
                res.dbf = 1'b1;
            end else begin
                nq = (longint'(absd - dz) << 16) / longint'(span - dz);
                ex = (sh_expo > EXPO_CAP) ? EXPO_CAP : sh_expo;
                lim = (sh_limit > LIM_CAP) ? LIM_CAP : sh_limit;
                if (nq > UNIT) nq = UNIT;
                c = curve_power(int'(nq), 256 + ex);
                mag = int'((longint'(c) * lim + 128) >> 8);
            end
        end else begin
            v = (longint'(absd) * LIN_FULL + span / 2) / span;
            mag = (v > LIN_FULL) ? LIN_FULL : int'(v);
        end
        res.pos = neg ? 16'(0 - mag) : 16'(mag);
        return res;
    endfunction

    // driver: if a beat is taken or none is up, send the next or idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) want_q.push_back(shape_sample(i_cmd, i_raw_sample));
            if (!start || !busy) begin
                if (pending_q.size() != 0 && (quiet_phase || $urandom_range(99) >= 27)) begin
                    t_sample it;
                    it = pending_q.pop_front();
                    start <= 1'b1;
                    i_cmd <= it.cmd;
                    i_raw_sample <= it.raw;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobe must match the oldest expected position
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (want_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat: pos=%0d dbf=%0b",
                                           o_position, o_in_dead_band);
            end else begin
                t_stick w;
                w = want_q.pop_front();
                if (w.dbf) dead_seen++;
                if (o_position !== w.pos || o_in_dead_band !== w.dbf) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: pos exp=%0d got=%0d dbf exp=%0b got=%0b",
                                 $signed(w.pos), o_position, w.dbf, o_in_dead_band);
                end
            end
        end
    end

    task automatic write_regs(input int unsigned inv, lo, hi, mid, dead, expo, lim);
        int unsigned vals [7];
        vals = '{inv, lo, hi, mid, dead, expo, lim};
        for (int i = 0; i < 7; i++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 3'(i);
            i_cfg_data <= 12'(vals[i]);
        end
        // unused index, must be dropped
        @(posedge i_clk);
        i_cfg_idx <= REG_NONE;
        i_cfg_data <= 12'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sh_invert = inv & 1;
        sh_low = lo & 12'hFFF;
        sh_high = hi & 12'hFFF;
        sh_mid = mid & 12'hFFF;
        sh_dead = dead & 11'h7FF;
        sh_expo = expo & 10'h3FF;
        sh_limit = lim & 7'h7F;
    endtask

    task automatic add_sample(input logic cmd, input int raw);
        t_sample it;
        it.cmd = cmd;
        it.raw = (raw < 0) ? 12'd0 : (raw > FULL) ? 12'(FULL) : 12'(raw);
        pending_q.push_back(it);
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || want_q.size() != 0 || start) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic run_directed();
        int pts [8];
        pts = '{0, 1, int'(sh_mid) - int'(sh_dead), int'(sh_mid),
                int'(sh_mid) + int'(sh_dead) + 1, 4094, 4095, int'($urandom_range(4095))};
        @(negedge i_clk);
        for (int i = 0; i < 8; i++) begin
            add_sample(CMD_SHAPED, pts[i]);
            add_sample(CMD_LINEAR, pts[i]);
        end
        drain();
    endtask

    task automatic run_random(input int count);
        int c, dz;
        @(negedge i_clk);
        for (int i = 0; i < count; i++) begin
            dz = (sh_dead > DZ_MAX) ? DZ_MAX : sh_dead;
            case ($urandom_range(3))
                0: c = $urandom_range(4095);
                1: c = int'(sh_mid) + int'($urandom_range(2 * dz + 80)) - dz - 40;
                2: c = $urandom_range(1) ? 4095 : 0;
                default: c = int'($urandom_range(1) ? sh_high : sh_low)
                             + int'($urandom_range(16)) - 8;
            endcase
            add_sample($urandom_range(3) == 0 ? CMD_LINEAR : CMD_SHAPED, c);
        end
        drain();
    endtask

    initial begin
        int unsigned lo, hi;
        build_curves();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        write_regs(1, 100, 4000, 2000, 100, 256, 50);
        run_directed();
        // degenerate range, center out of range, registers above caps
        write_regs(0, 2000, 2002, 3000, 2047, 1023, 127);
        run_directed();
        // rest at the low end leaves no negative span
        write_regs(1, 0, 4095, 0, 0, 768, 0);
        run_directed();
        write_regs(0, 0, 4095, 4095, 1601, 1, 100);
        run_directed();

        for (int ph = 0; ph < 12; ph++) begin
            lo = $urandom_range(1200);
            hi = 4095 - $urandom_range(1200);
            if (ph == 5) hi = lo + $urandom_range(2);
            write_regs($urandom_range(1), lo, hi,
                       (ph % 3 == 0) ? $urandom_range(4095) : $urandom_range(hi, lo),
                       ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(300),
                       $urandom_range(1023), $urandom_range(127));
            quiet_phase = (ph % 4 == 2);
            run_random(160);
        end
        quiet_phase = 1'b0;

        if (want_q.size() != 0) errors++;
        $display("covered %0d results, %0d in dead band, over 17 register settings",
                 results_seen, dead_seen);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
rtl/jas_pkg.sv
rtl/jas_front.sv
rtl/jas_div.sv
rtl/jas_curve.sv
rtl/joystick_axis_shaper.sv
sim/tb.sv
